// ----- hdl/tlca_pkg.sv -----
package tlca_pkg;

   localparam int NODE_W = 10;
   localparam int DIST_W = 27;
   localparam int DEPTH_W = 10;
   localparam int WEIGHT_W = 16;

   localparam int DEF_NODES = 1024;
   localparam int DEF_LEVELS = 10;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_BAD_ADD = 2'd1;
   localparam logic [1:0] ST_BAD_QUERY = 2'd2;

   typedef struct packed {
      logic                 loaded;
      logic [DEPTH_W-1:0]   depth;
      logic [DIST_W-1:0]    root_dist;
   } info_type;

   localparam int INFO_W = $bits(info_type);

endpackage

// ----- hdl/tree_lca_distance_query_core.sv -----
// Weighted tree engine, lowest common ancestor by binary lifting.
// Request channel: start/busy with req_func, req_node_a, req_node_b, req_weight.
//   A request is taken on a clock edge with start high and busy low.
//   req_func add: load node_a under parent node_b (0 = root) with edge weight.
//   req_func query: return LCA of node_a and node_b and their path distance.
// Result channel: rsp_valid strobes for one cycle with rsp_ancestor,
//   rsp_distance and rsp_status. The receiver cannot stall; results are
//   never held.
// Sequence: a request with an invalid node id is answered from the check
//   state, a rejected add or a query of an unloaded node after the node info
//   reads. An add writes level 0 with the parent, then does one ancestor
//   table read and write per higher level.
//   A query reads the node info, lifts the deeper node in a depth
//   equalizing pass, then runs a joint pass with two reads per level on the
//   single ancestor table read port (the top level repeated while it moves),
//   then does the final reads and gives the result. One request at a time.
// Reset: after reset the node info memory is cleared one entry per cycle,
//   all NODES entries, with busy high. Loaded nodes are lost at reset.
module tree_lca_distance_query_core
   import tlca_pkg::*;
#(
   parameter int NODES = DEF_NODES,
   parameter int LEVELS = DEF_LEVELS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [NODE_W-1:0]   req_node_a,
   input  logic [NODE_W-1:0]   req_node_b,
   input  logic [WEIGHT_W-1:0] req_weight,
   output logic                rsp_valid,
   output logic [NODE_W-1:0]   rsp_ancestor,
   output logic [DIST_W-1:0]   rsp_distance,
   output logic [1:0]          rsp_status
);

   localparam int IDX_W = $clog2(NODES);
   localparam int LW = $clog2(LEVELS);
   localparam int ANC_DEPTH = NODES << LW;
   localparam int ANC_AW = IDX_W + LW;
   localparam logic [LW-1:0] TOP = LW'(LEVELS - 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);
   localparam int WB = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
   localparam logic [WEIGHT_W-1:0] WMASK = WEIGHT_W'((33'd1 << WB) - 33'd1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHK, S_RD_B, S_GOT_B, S_ANC, S_ANC_W,
      S_P1, S_P1W, S_P2U, S_P2V, S_P2C, S_FIN, S_FINW, S_DL, S_DLW
   } state_type;

   state_type state_ff;
   logic [IDX_W-1:0]    cnt_ff;
   logic                func_ff;
   logic [NODE_W-1:0]   a_ff, b_ff, u_ff, v_ff, au_ff, prev_ff, lca_ff;
   logic [WEIGHT_W-1:0] w_ff;
   logic [DEPTH_W-1:0]  diff_ff;
   logic [LW-1:0]       lvl_ff;
   logic [DIST_W-1:0]   dsum_ff;
   info_type            info_a_ff;
   logic                rsp_valid_ff;
   logic [NODE_W-1:0]   rsp_ancestor_ff;
   logic [DIST_W-1:0]   rsp_distance_ff;
   logic [1:0]          rsp_status_ff;

   logic                info_we;
   logic [IDX_W-1:0]    info_waddr, info_raddr;
   info_type            info_wdata, info_rd;
   logic [INFO_W-1:0]   info_rd_raw;
   logic                anc_we;
   logic [ANC_AW-1:0]   anc_waddr, anc_raddr;
   logic [NODE_W-1:0]   anc_wdata, anc_rd;

   logic                add_ok;
   logic [DEPTH_W-1:0]  new_depth;
   logic [DIST_W-1:0]   new_dist;
   logic [LW-1:0]       p1_lvl;
   logic [NODE_W-1:0]   anc_next;

   function automatic logic [LW-1:0] pick_level(input logic [DEPTH_W-1:0] d);
      logic [LW-1:0] r;
      r = '0;
      for (int k = 0; k < DEPTH_W; k++) begin
         if (d[k]) begin
            r = (k > LEVELS - 1) ? TOP : LW'(k);
         end
      end
      return r;
   endfunction

   function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] n,
                                                  input logic [LW-1:0] l);
      return {IDX_W'(n), l};
   endfunction

   assign info_rd = info_type'(info_rd_raw);
   assign add_ok = !info_a_ff.loaded && (b_ff == '0 || info_rd.loaded);
   assign new_depth = (b_ff == '0) ? DEPTH_W'(1) : info_rd.depth + DEPTH_W'(1);
   assign new_dist = ((b_ff == '0) ? '0 : info_rd.root_dist) + DIST_W'(w_ff & WMASK);
   assign p1_lvl = pick_level(diff_ff);
   assign anc_next = (prev_ff == '0) ? '0 : anc_rd;

   always_comb begin
      info_we = 1'b0;
      info_waddr = IDX_W'(a_ff);
      info_wdata = '{loaded: 1'b1, depth: new_depth, root_dist: new_dist};
      info_raddr = IDX_W'(a_ff);
      anc_we = 1'b0;
      anc_waddr = anc_addr(a_ff, lvl_ff);
      anc_wdata = anc_next;
      anc_raddr = anc_addr(u_ff, lvl_ff);
      unique case (state_ff)
         S_CLEAR: begin
            info_we = 1'b1;
            info_waddr = cnt_ff;
            info_wdata = '0;
         end
         S_RD_B: info_raddr = IDX_W'(b_ff);
         S_GOT_B: begin
            if (func_ff == FUNC_ADD && add_ok) begin
               info_we = 1'b1;
               anc_we = 1'b1;
               anc_waddr = anc_addr(a_ff, '0);
               anc_wdata = b_ff;
            end
         end
         S_ANC: anc_raddr = anc_addr(prev_ff, lvl_ff - LW'(1));
         S_ANC_W: anc_we = 1'b1;
         S_P1: anc_raddr = anc_addr(u_ff, p1_lvl);
         S_P2V: anc_raddr = anc_addr(v_ff, lvl_ff);
         S_FIN: anc_raddr = anc_addr(u_ff, '0);
         S_DL: info_raddr = IDX_W'(lca_ff);
         default: ;
      endcase
   end

   tlca_ram #(.WIDTH(INFO_W), .DEPTH(NODES)) u_info_ram (
      .clock   (clock),
      .wr_en   (info_we),
      .wr_addr (info_waddr),
      .wr_data (info_wdata),
      .rd_addr (info_raddr),
      .rd_data (info_rd_raw)
   );

   tlca_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
      .clock   (clock),
      .wr_en   (anc_we),
      .wr_addr (anc_waddr),
      .wr_data (anc_wdata),
      .rd_addr (anc_raddr),
      .rd_data (anc_rd)
   );

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + IDX_W'(1);
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  func_ff <= req_func;
                  a_ff <= req_node_a;
                  b_ff <= req_node_b;
                  w_ff <= req_weight;
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               rsp_ancestor_ff <= '0;
               rsp_distance_ff <= '0;
               if (func_ff == FUNC_ADD) begin
                  rsp_status_ff <= ST_BAD_ADD;
                  if (a_ff == '0 || 32'(a_ff) >= NODES ||
                      (b_ff != '0 && 32'(b_ff) >= NODES)) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_RD_B;
                  end
               end else begin
                  rsp_status_ff <= ST_BAD_QUERY;
                  if (a_ff == '0 || b_ff == '0 || 32'(a_ff) >= NODES ||
                      32'(b_ff) >= NODES) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_RD_B;
                  end
               end
            end
            S_RD_B: begin
               info_a_ff <= info_rd;
               state_ff <= S_GOT_B;
            end
            S_GOT_B: begin
               if (func_ff == FUNC_ADD) begin
                  if (add_ok) begin
                     dsum_ff <= new_dist;
                     prev_ff <= b_ff;
                     lvl_ff <= LW'(1);
                     state_ff <= S_ANC;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else begin
                  if (!info_a_ff.loaded || !info_rd.loaded) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     dsum_ff <= info_a_ff.root_dist + info_rd.root_dist;
                     if (info_a_ff.depth < info_rd.depth) begin
                        u_ff <= b_ff;
                        v_ff <= a_ff;
                        diff_ff <= info_rd.depth - info_a_ff.depth;
                     end else begin
                        u_ff <= a_ff;
                        v_ff <= b_ff;
                        diff_ff <= info_a_ff.depth - info_rd.depth;
                     end
                     state_ff <= S_P1;
                  end
               end
            end
            S_ANC: state_ff <= S_ANC_W;
            S_ANC_W: begin
               prev_ff <= anc_next;
               if (lvl_ff == TOP) begin
                  rsp_status_ff <= ST_OK;
                  rsp_distance_ff <= dsum_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  lvl_ff <= lvl_ff + LW'(1);
                  state_ff <= S_ANC;
               end
            end
            S_P1: begin
               if (diff_ff == '0) begin
                  lvl_ff <= TOP;
                  if (u_ff == v_ff) begin
                     lca_ff <= u_ff;
                     state_ff <= S_DL;
                  end else begin
                     state_ff <= S_P2U;
                  end
               end else begin
                  diff_ff <= diff_ff - (DEPTH_W'(1) << p1_lvl);
                  state_ff <= S_P1W;
               end
            end
            S_P1W: begin
               u_ff <= anc_rd;
               state_ff <= S_P1;
            end
            S_P2U: state_ff <= S_P2V;
            S_P2V: begin
               au_ff <= anc_rd;
               state_ff <= S_P2C;
            end
            S_P2C: begin
               if (au_ff != '0 && au_ff != anc_rd) begin
                  u_ff <= au_ff;
                  v_ff <= anc_rd;
               end
               if ((au_ff != '0 && au_ff != anc_rd) && lvl_ff == TOP) begin
                  state_ff <= S_P2U;
               end else if (lvl_ff == '0) begin
                  state_ff <= S_FIN;
               end else begin
                  lvl_ff <= lvl_ff - LW'(1);
                  state_ff <= S_P2U;
               end
            end
            S_FIN: state_ff <= S_FINW;
            S_FINW: begin
               lca_ff <= anc_rd;
               state_ff <= S_DL;
            end
            S_DL: begin
               if (lca_ff == '0) begin
                  rsp_ancestor_ff <= '0;
                  rsp_distance_ff <= dsum_ff;
                  rsp_status_ff <= ST_OK;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_DLW;
               end
            end
            S_DLW: begin
               rsp_ancestor_ff <= lca_ff;
               rsp_distance_ff <= dsum_ff - {info_rd.root_dist[DIST_W-2:0], 1'b0};
               rsp_status_ff <= ST_OK;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ancestor = rsp_ancestor_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_status = rsp_status_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_ancestor == '0 && rsp_distance == '0))
      else $error("error result carries data");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("request not taken into work");

   a_add_no_ancestor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BAD_ADD) |-> $past(func_ff == FUNC_ADD))
      else $error("add status on a query");

endmodule

// ----- hdl/tlca_ram.sv -----
module tlca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/sv/tlca_checker.sv -----
`timescale 1ns / 1ps

module tlca_checker
   import tlca_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_func,
   input  logic [NODE_W-1:0]   req_node_a,
   input  logic [NODE_W-1:0]   req_node_b,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic                rsp_valid,
   input  logic [NODE_W-1:0]   rsp_ancestor,
   input  logic [DIST_W-1:0]   rsp_distance,
   input  logic [1:0]          rsp_status,
   output int                  pending,
   output int                  fails
);

   localparam int LVL = DEF_LEVELS;

   typedef struct {
      logic [NODE_W-1:0] ancestor;
      logic [DIST_W-1:0] distance;
      logic [1:0]        status;
   } answer_type;

   answer_type answer_q[$];

   logic [NODE_W-1:0]  jump[DEF_NODES][LVL];
   logic [DEPTH_W-1:0] level_of[DEF_NODES];
   logic [DIST_W-1:0]  dist_to_root[DEF_NODES];
   logic               present[DEF_NODES];

   assign pending = answer_q.size();

   function automatic logic [NODE_W-1:0] hop(logic [NODE_W-1:0] x, int l);
      if (x == 0) return '0;
      return jump[x][l];
   endfunction

   function automatic logic [DEPTH_W-1:0] lvl_of(logic [NODE_W-1:0] x);
      return (x == 0) ? '0 : level_of[x];
   endfunction

   function automatic logic [DIST_W-1:0] dist_of(logic [NODE_W-1:0] x);
      return (x == 0) ? '0 : dist_to_root[x];
   endfunction

   function automatic logic [NODE_W-1:0] common_ancestor(logic [NODE_W-1:0] u,
                                                         logic [NODE_W-1:0] v);
      logic [NODE_W-1:0] t, au, av;
      int diff;
      if (lvl_of(u) < lvl_of(v)) begin
         t = u; u = v; v = t;
      end
      diff = lvl_of(u) - lvl_of(v);
      for (int i = LVL - 1; i >= 0; i--) begin
         while (diff >= (1 << i)) begin
            u = hop(u, i);
            diff -= (1 << i);
         end
      end
      if (u == v) return u;
      for (int i = LVL - 1; i >= 0; i--) begin
         forever begin
            au = hop(u, i);
            av = hop(v, i);
            if (au == 0 || au == av) break;
            u = au;
            v = av;
            if (i != LVL - 1) break;
         end
      end
      return hop(u, 0);
   endfunction

   function automatic answer_type resolve_request(logic f, logic [NODE_W-1:0] a,
                                                  logic [NODE_W-1:0] b,
                                                  logic [WEIGHT_W-1:0] w);
      answer_type r;
      logic [NODE_W-1:0] l;
      r.ancestor = '0;
      r.distance = '0;
      r.status = ST_OK;
      if (f == FUNC_ADD) begin
         if (a == 0 || present[a] || (b != 0 && !present[b])) begin
            r.status = ST_BAD_ADD;
            return r;
         end
         level_of[a] = lvl_of(b) + 1'b1;
         dist_to_root[a] = dist_of(b) + w;
         jump[a][0] = b;
         for (int i = 1; i < LVL; i++) jump[a][i] = hop(jump[a][i-1], i - 1);
         present[a] = 1'b1;
         r.distance = dist_to_root[a];
         return r;
      end
      if (a == 0 || b == 0 || !present[a] || !present[b]) begin
         r.status = ST_BAD_QUERY;
         return r;
      end
      l = common_ancestor(a, b);
      r.ancestor = l;
      r.distance = dist_of(a) + dist_of(b) - 2 * dist_of(l);
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fails++;
   endtask

   always @(posedge clock) begin
      answer_type e;
      if (reset) begin
         for (int i = 0; i < DEF_NODES; i++) present[i] = 1'b0;
         answer_q.delete();
         fails = 0;
      end else begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               report("unexpected response", 1, 0);
            end else begin
               e = answer_q.pop_front();
               if (rsp_ancestor !== e.ancestor) report("ancestor", rsp_ancestor, e.ancestor);
               if (rsp_distance !== e.distance) report("distance", rsp_distance, e.distance);
               if (rsp_status !== e.status) report("status", rsp_status, e.status);
            end
         end
         if (start && !busy) begin
            e = resolve_request(req_func, req_node_a, req_node_b, req_weight);
            answer_q = {answer_q, e};
         end
      end
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import tlca_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_func = FUNC_ADD;
   logic [NODE_W-1:0]   req_node_a = '0;
   logic [NODE_W-1:0]   req_node_b = '0;
   logic [WEIGHT_W-1:0] req_weight = '0;
   logic                rsp_valid;
   logic [NODE_W-1:0]   rsp_ancestor;
   logic [DIST_W-1:0]   rsp_distance;
   logic [1:0]          rsp_status;
   int                  pending;
   int                  fails;

   logic                loaded[DEF_NODES];
   logic [NODE_W-1:0]   tree_nodes[$];
   bit                  idle_ok = 1'b1;

   always #6 clock = ~clock;

   tree_lca_distance_query_core dut (.*);

   tlca_checker u_checker (.*);

   task automatic send(logic f, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                       logic [WEIGHT_W-1:0] w);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_node_a <= a;
      req_node_b <= b;
      req_weight <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (f == FUNC_ADD && a != 0 && !loaded[a] && (b == 0 || loaded[b])) begin
         loaded[a] = 1'b1;
         tree_nodes = {tree_nodes, a};
      end
   endtask

   function automatic logic [NODE_W-1:0] pick_loaded();
      int n;
      n = tree_nodes.size();
      if (n == 0) return NODE_W'(1);
      if ($urandom_range(0, 1)) return tree_nodes[$urandom_range(n - 1, (n > 8) ? n - 8 : 0)];
      return tree_nodes[$urandom_range(0, n - 1)];
   endfunction

   function automatic logic [NODE_W-1:0] pick_free();
      logic [NODE_W-1:0] x;
      for (int k = 0; k < 50; k++) begin
         x = NODE_W'($urandom_range(1, DEF_NODES - 1));
         if (!loaded[x]) return x;
      end
      return x;
   endfunction

   initial begin
      for (int i = 0; i < DEF_NODES; i++) loaded[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send(FUNC_QUERY, 1, 1, 0);
      send(FUNC_ADD, 1, 0, 16'hFFFF);
      send(FUNC_ADD, 1023, 1, 16'hFFFF);
      send(FUNC_ADD, 2, 1, 16'h0000);
      send(FUNC_ADD, 0, 1, 16'h1234);
      send(FUNC_ADD, 2, 1, 16'h0001);
      send(FUNC_ADD, 5, 700, 16'h0001);
      send(FUNC_ADD, 512, 0, 16'h8000);
      send(FUNC_ADD, 3, 1023, 16'h5555);
      send(FUNC_ADD, 4, 3, 16'hAAAA);
      send(FUNC_QUERY, 1023, 1023, 0);
      send(FUNC_QUERY, 4, 2, 16'hFFFF);
      send(FUNC_QUERY, 4, 512, 0);
      send(FUNC_QUERY, 1, 4, 0);
      send(FUNC_QUERY, 0, 4, 0);
      send(FUNC_QUERY, 4, 0, 0);
      send(FUNC_QUERY, 4, 700, 0);
      send(FUNC_QUERY, 1022, 1, 0);

      for (int n = 0; n < 900; n++) begin
         int r;
         if (n == 450) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         if (n == 800) idle_ok = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 40 && tree_nodes.size() < DEF_NODES - 1)
            send(FUNC_ADD, pick_free(), ($urandom_range(0, 9) == 0) ? '0 : pick_loaded(),
                 WEIGHT_W'($urandom()));
         else if (r < 88)
            send(FUNC_QUERY, pick_loaded(), pick_loaded(), WEIGHT_W'($urandom()));
         else if (r < 94)
            send(FUNC_ADD, NODE_W'($urandom()), NODE_W'($urandom()), WEIGHT_W'($urandom()));
         else
            send(FUNC_QUERY, NODE_W'($urandom()), NODE_W'($urandom()),
                 WEIGHT_W'($urandom()));
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fails == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
